>>> hdl/grmc_pkg.sv
// ---------------------------------------------------------------------------
// grmc_pkg
// Types, constants and codes shared by the maximum-intensity projection block.
// ---------------------------------------------------------------------------
package grmc_pkg;

    localparam int GRID_COLS  = 256;
    localparam int GRID_ROWS  = 256;
    localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    localparam int IDX_W     = 10;
    localparam int STEP_W    = 24;
    localparam int OFS_W     = 32;
    localparam int PROD_W    = IDX_W + STEP_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int FRAC_W    = 16;
    localparam int CELL_W    = SUM_W - FRAC_W - 1;
    localparam int SIZE_W    = 9;
    localparam int HEIGHT_W  = 16;
    localparam int VALUE_W   = 8;
    localparam int COORD_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [SUM_W-1:0] HALF_Q16 = SUM_W'(32'h8000);

    typedef enum logic {
        OP_ACCUM = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_UPDATED  = 2'd0,
        ST_BAND     = 2'd1,
        ST_OFF_GRID = 2'd2,
        ST_READ     = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_OFFSET   = 3'd0,
        CFG_X_STEP     = 3'd1,
        CFG_Y_OFFSET   = 3'd2,
        CFG_Y_STEP     = 3'd3,
        CFG_OUT_WIDTH  = 3'd4,
        CFG_OUT_HEIGHT = 3'd5,
        CFG_MIN_HEIGHT = 3'd6,
        CFG_MAX_HEIGHT = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_MAP,
        S_RMW,
        S_OUT
    } t_state;

    typedef struct packed {
        t_op                        operation;
        logic [IDX_W-1:0]           voxel_x;
        logic [IDX_W-1:0]           voxel_y;
        logic signed [HEIGHT_W-1:0] plane_height;
        logic [VALUE_W-1:0]         voxel_value;
        logic [COORD_W-1:0]         read_x;
        logic [COORD_W-1:0]         read_y;
    } t_vox_req;

    typedef struct packed {
        logic [COORD_W-1:0] target_x;
        logic [COORD_W-1:0] target_y;
        logic [VALUE_W-1:0] cell_value;
        t_status            status;
    } t_res;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] value;
    } t_cfg_req;

endpackage

>>> hdl/grmc_ifs.sv
// ---------------------------------------------------------------------------
// grmc_ifs
// Valid/ready channels for voxel requests, results and register writes.
// ---------------------------------------------------------------------------
interface grmc_vox_if;
    import grmc_pkg::*;
    logic     valid;
    logic     ready;
    t_vox_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface grmc_res_if;
    import grmc_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface grmc_cfg_if;
    import grmc_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/grmc_ram.sv
// ---------------------------------------------------------------------------
// grmc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module grmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/grmc_axis_map.sv
// ---------------------------------------------------------------------------
// grmc_axis_map
// Nearest-cell mapping of one axis: registered index times step, then the
// Q16.16 offset and half-cell rounding, floor and the grid bounds check.
// ---------------------------------------------------------------------------
module grmc_axis_map (
    input  logic                          i_clk,
    input  logic [grmc_pkg::IDX_W-1:0]    i_index,
    input  logic [grmc_pkg::STEP_W-1:0]   i_step,
    input  logic [grmc_pkg::OFS_W-1:0]    i_offset,
    input  logic [grmc_pkg::SIZE_W-1:0]   i_limit,
    output logic [grmc_pkg::CELL_W-1:0]   o_cell,
    output logic                          o_on_grid
);
    import grmc_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic [SUM_W-1:0]  w_sum;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_index) * PROD_W'(i_step);
    end

    assign w_sum = {{(SUM_W - OFS_W){i_offset[OFS_W-1]}}, i_offset}
                 + {{(SUM_W - PROD_W){1'b0}}, r_prod}
                 + HALF_Q16;

    assign o_cell    = w_sum[SUM_W-2:FRAC_W];
    assign o_on_grid = !w_sum[SUM_W-1] && (o_cell < CELL_W'(i_limit));

endmodule

>>> hdl/grid_remap_max_composite.sv
// ---------------------------------------------------------------------------
// grid_remap_max_composite
// Nearest-neighbour maximum-intensity projection of a voxel stream onto a
// two-dimensional grid of 8-bit cells held in one synchronous RAM.
//
// Requests arrive on i_vox: an accumulate request maps the voxel to its
// nearest cell and keeps the running maximum there, a read request returns
// one cell and clears it. Every request yields exactly one result on o_res.
// Registers are written through i_cfg, which is always ready; write them
// only while no request is in progress.
// A sequencer steps each request through the index multiply, the mapping
// and bounds check, and, when a cell is read or updated, a read-modify-write
// of the cell RAM. The result is loaded into the output register, and a
// request is taken only after the last one is through (the next one is
// accepted in the cycle after the result is loaded).
// After reset the RAM is swept to zero, one cell a cycle, through every cell,
// during which i_vox is not ready. A stalled result waits in the output
// register; the next request is still accepted and runs until its own
// result is ready to be loaded.
// ---------------------------------------------------------------------------
module grid_remap_max_composite (
    input  logic    i_clk,
    input  logic    i_rst_n,
    grmc_vox_if.sink   i_vox,
    grmc_res_if.source o_res,
    grmc_cfg_if.sink   i_cfg
);
    import grmc_pkg::*;

    t_state                     r_state, n_state;
    logic [OFS_W-1:0]           r_x_offset, r_y_offset;
    logic [STEP_W-1:0]          r_x_step, r_y_step;
    logic [SIZE_W-1:0]          r_out_width, r_out_height;
    logic signed [HEIGHT_W-1:0] r_min_height, r_max_height;
    logic [ADDR_W-1:0]          r_clr_addr;
    t_vox_req                   r_item;
    logic                       r_in_band;
    logic                       r_access, n_access;
    logic [ADDR_W-1:0]          r_addr, n_addr;
    t_res                       r_res, n_res;
    logic                       r_out_valid;
    t_res                       r_out;

    logic [SIZE_W-1:0]  w_x_limit, w_y_limit;
    logic [CELL_W-1:0]  w_cx, w_cy;
    logic               w_x_on, w_y_on;
    logic               w_mem_we;
    logic [ADDR_W-1:0]  w_mem_waddr;
    logic [VALUE_W-1:0] w_mem_wdata, w_mem_rdata, w_new_max;
    logic               w_load_out;

    assign w_x_limit = (32'(r_out_width) < GRID_COLS) ? r_out_width : SIZE_W'(GRID_COLS);
    assign w_y_limit = (32'(r_out_height) < GRID_ROWS) ? r_out_height : SIZE_W'(GRID_ROWS);

    grmc_axis_map u_map_x (
        .i_clk     (i_clk),
        .i_index   (r_item.voxel_x),
        .i_step    (r_x_step),
        .i_offset  (r_x_offset),
        .i_limit   (w_x_limit),
        .o_cell    (w_cx),
        .o_on_grid (w_x_on)
    );

    grmc_axis_map u_map_y (
        .i_clk     (i_clk),
        .i_index   (r_item.voxel_y),
        .i_step    (r_y_step),
        .i_offset  (r_y_offset),
        .i_limit   (w_y_limit),
        .o_cell    (w_cy),
        .o_on_grid (w_y_on)
    );

    grmc_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CELL_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (n_addr),
        .o_rdata (w_mem_rdata)
    );

    assign w_new_max = (w_mem_rdata < r_item.voxel_value) ? r_item.voxel_value : w_mem_rdata;

    assign i_vox.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;
    assign w_load_out  = (r_state == S_OUT) && (!r_out_valid || o_res.ready);

    always_comb begin
        n_state     = r_state;
        n_access    = r_access;
        n_addr      = r_addr;
        n_res       = r_res;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_addr;
        w_mem_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr_addr;
                if (r_clr_addr == ADDR_W'(CELL_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_vox.valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_MAP;
            end
            S_MAP: begin
                n_res    = '{target_x: '0, target_y: '0, cell_value: '0, status: ST_UPDATED};
                n_access = 1'b0;
                if (r_item.operation == OP_READ) begin
                    n_res.target_x = r_item.read_x;
                    n_res.target_y = r_item.read_y;
                    n_res.status   = ST_READ;
                    if (32'(r_item.read_x) < GRID_COLS && 32'(r_item.read_y) < GRID_ROWS) begin
                        n_access = 1'b1;
                        n_addr   = ADDR_W'(32'(r_item.read_y) * GRID_COLS
                                           + 32'(r_item.read_x));
                    end
                end else if (!r_in_band) begin
                    n_res.status = ST_BAND;
                end else if (!(w_x_on && w_y_on)) begin
                    n_res.status = ST_OFF_GRID;
                end else begin
                    n_res.target_x = w_cx[COORD_W-1:0];
                    n_res.target_y = w_cy[COORD_W-1:0];
                    n_access       = 1'b1;
                    n_addr         = ADDR_W'(32'(w_cy) * GRID_COLS + 32'(w_cx));
                end
                n_state = n_access ? S_RMW : S_OUT;
            end
            S_RMW: begin
                w_mem_we = 1'b1;
                if (r_item.operation == OP_READ) begin
                    w_mem_wdata      = '0;
                    n_res.cell_value = w_mem_rdata;
                end else begin
                    w_mem_wdata      = w_new_max;
                    n_res.cell_value = w_new_max;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_access    <= 1'b0;
        end else begin
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            r_access <= n_access;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_res  <= n_res;
        if (i_vox.valid && i_vox.ready) begin
            r_item <= i_vox.data;
        end
        if (r_state == S_MUL) begin
            r_in_band <= (r_item.plane_height >= r_min_height)
                      && (r_item.plane_height <= r_max_height);
        end
        if (w_load_out) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_offset   <= '0;
            r_x_step     <= STEP_W'(32'h10000);
            r_y_offset   <= '0;
            r_y_step     <= STEP_W'(32'h10000);
            r_out_width  <= SIZE_W'(256);
            r_out_height <= SIZE_W'(256);
            r_min_height <= HEIGHT_W'(16'h8000);
            r_max_height <= HEIGHT_W'(16'h7FFF);
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.data.index))
                CFG_X_OFFSET:   r_x_offset   <= i_cfg.data.value;
                CFG_X_STEP:     r_x_step     <= i_cfg.data.value[STEP_W-1:0];
                CFG_Y_OFFSET:   r_y_offset   <= i_cfg.data.value;
                CFG_Y_STEP:     r_y_step     <= i_cfg.data.value[STEP_W-1:0];
                CFG_OUT_WIDTH:  r_out_width  <= i_cfg.data.value[SIZE_W-1:0];
                CFG_OUT_HEIGHT: r_out_height <= i_cfg.data.value[SIZE_W-1:0];
                CFG_MIN_HEIGHT: r_min_height <= i_cfg.data.value[HEIGHT_W-1:0];
                CFG_MAX_HEIGHT: r_max_height <= i_cfg.data.value[HEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule
